FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers for the lexer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rstn, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif
`endif

FILE: hdl/slex_pkg.sv
// ----------------------------------------------------------------------------
// slex_pkg
// Modes, codes, keyword table and character classes of the script lexer.
// ----------------------------------------------------------------------------
package slex_pkg;

    localparam int MAX_WORD_LEN_DEF = 14;
    localparam int POS_WIDTH_DEF    = 16;

    localparam int NUM_KW     = 36;
    localparam int KW_MAX_LEN = 14;

    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KW] = '{
        "false", "true", "if", "else", "and", "or", "xor", "abs", "cast",
        "boolean", "object", "string", "integer", "float", "matrix", "vector",
        "list", "dot", "cross", "sin", "cos", "tan", "asin", "acos", "atan",
        "exp", "log", "sqrt", "atan2", {"make_", "rotate"}, {"make_", "rotatex"},
        {"make_", "rotatey"}, {"make_", "rotatez"}, {"make_", "scale"},
        {"make_", "translate"}, "pi"
    };
    localparam int KW_LEN [NUM_KW] = '{
        5, 4, 2, 4, 3, 2, 3, 3, 4, 7, 6, 6, 7, 5, 6, 6, 4, 3, 5, 3, 3, 3,
        4, 4, 4, 3, 3, 4, 5, 11, 12, 12, 12, 10, 14, 2
    };
    localparam logic [6:0] KW_TYPE [NUM_KW] = '{
        7'd4, 7'd4, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10, 7'd11, 7'd12, 7'd13,
        7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22,
        7'd23, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29, 7'd30, 7'd31,
        7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38, 7'd65
    };

    typedef enum logic [5:0] {
        MODE_IDLE, MODE_SLASH, MODE_LCOM, MODE_BCOM, MODE_BSTAR, MODE_DOT,
        MODE_INT, MODE_FRAC, MODE_EXP, MODE_ESIGN, MODE_EDIG, MODE_WORD,
        MODE_STR, MODE_SCLOSE, MODE_SSLASH, MODE_SLCOM, MODE_SBCOM,
        MODE_SBSTAR, MODE_ESC, MODE_HEX2, MODE_HEX4, MODE_HEX8, MODE_BADSURR,
        MODE_BADRANGE, MODE_LT, MODE_GT, MODE_EQ, MODE_STAR, MODE_BANG,
        MODE_PEND, MODE_HELD, MODE_EOFPEND, MODE_END
    } lex_mode_t;

    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_EOF   = 2'd3;

    localparam logic [3:0] ERR_EXP_DIGITS = 4'd0;
    localparam logic [3:0] ERR_UNCLOSED_COMMENT = 4'd1;
    localparam logic [3:0] ERR_BAD_ESCAPE = 4'd2;
    localparam logic [3:0] ERR_HEX_DIGIT = 4'd3;
    localparam logic [3:0] ERR_SURROGATE = 4'd4;
    localparam logic [3:0] ERR_RANGE = 4'd5;
    localparam logic [3:0] ERR_UNCLOSED_STRING = 4'd6;
    localparam logic [3:0] ERR_LONE_BANG = 4'd7;
    localparam logic [3:0] ERR_ILLEGAL_CHAR = 4'd8;

    localparam logic [6:0] TT_NONE = 7'd0;
    localparam logic [6:0] TT_INTEGER = 7'd1;
    localparam logic [6:0] TT_FLOAT = 7'd2;
    localparam logic [6:0] TT_STRING = 7'd3;
    localparam logic [6:0] TT_IDENT = 7'd5;
    localparam logic [6:0] TT_LBRACKET = 7'd39;
    localparam logic [6:0] TT_RBRACKET = 7'd40;
    localparam logic [6:0] TT_LBRACE = 7'd41;
    localparam logic [6:0] TT_RBRACE = 7'd42;
    localparam logic [6:0] TT_COMMA = 7'd43;
    localparam logic [6:0] TT_PIPE = 7'd44;
    localparam logic [6:0] TT_LPAREN = 7'd45;
    localparam logic [6:0] TT_RPAREN = 7'd46;
    localparam logic [6:0] TT_LT = 7'd47;
    localparam logic [6:0] TT_GT = 7'd48;
    localparam logic [6:0] TT_ASSIGN = 7'd49;
    localparam logic [6:0] TT_EQ = 7'd50;
    localparam logic [6:0] TT_NE = 7'd51;
    localparam logic [6:0] TT_LE = 7'd52;
    localparam logic [6:0] TT_GE = 7'd53;
    localparam logic [6:0] TT_PLUS = 7'd54;
    localparam logic [6:0] TT_MINUS = 7'd55;
    localparam logic [6:0] TT_STAR = 7'd56;
    localparam logic [6:0] TT_SLASH = 7'd57;
    localparam logic [6:0] TT_PERCENT = 7'd58;
    localparam logic [6:0] TT_COLON = 7'd59;
    localparam logic [6:0] TT_SEMI = 7'd60;
    localparam logic [6:0] TT_QUESTION = 7'd61;
    localparam logic [6:0] TT_DOT = 7'd62;
    localparam logic [6:0] TT_POWER = 7'd63;
    localparam logic [6:0] TT_TILDE = 7'd64;

    localparam logic [21:0] CP_EOF   = 22'h200000;
    localparam logic [31:0] SURR_LO  = 32'h0000D800;
    localparam logic [31:0] SURR_HI  = 32'h0000DFFF;
    localparam logic [31:0] CP_LIMIT = 32'h00110000;
    localparam logic [20:0] CP_ESC   = 21'h00001B;

    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] text;
        logic [6:0]  ttype;
        logic [3:0]  err;
    } res_t;

    function automatic logic is_ch(input logic [21:0] c, input logic [7:0] a);
        return c == {14'd0, a};
    endfunction

    function automatic logic is_digit(input logic [21:0] c);
        return c >= 22'h30 && c <= 22'h39;
    endfunction

    function automatic logic is_alpha(input logic [21:0] c);
        return (c >= 22'h61 && c <= 22'h7A) || (c >= 22'h41 && c <= 22'h5A);
    endfunction

    function automatic logic is_word(input logic [21:0] c);
        return is_alpha(c) || is_digit(c) || is_ch(c, "_");
    endfunction

    function automatic logic is_space(input logic [21:0] c);
        return is_ch(c, " ") || (c >= 22'd9 && c <= 22'd13);
    endfunction

    function automatic logic [4:0] hex_val(input logic [21:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (is_digit(c)) d = 5'(c - 22'h30);
        else if (c >= 22'h41 && c <= 22'h46) d = 5'(c - 22'h37);
        else if (c >= 22'h61 && c <= 22'h66) d = 5'(c - 22'h57);
        return d;
    endfunction

    function automatic logic [6:0] single_type(input logic [21:0] c);
        logic [6:0] t;
        t = TT_NONE;
        if (c[21:8] == 14'd0) begin
            case (c[7:0])
                "[": t = TT_LBRACKET;
                "]": t = TT_RBRACKET;
                "{": t = TT_LBRACE;
                "}": t = TT_RBRACE;
                ",": t = TT_COMMA;
                "|": t = TT_PIPE;
                "(": t = TT_LPAREN;
                ")": t = TT_RPAREN;
                "+": t = TT_PLUS;
                "-": t = TT_MINUS;
                "%": t = TT_PERCENT;
                ":": t = TT_COLON;
                ";": t = TT_SEMI;
                "?": t = TT_QUESTION;
                "~": t = TT_TILDE;
                default: t = TT_NONE;
            endcase
        end
        return t;
    endfunction

    function automatic logic [6:0] kw_char(input int k, input int p);
        logic [8*KW_MAX_LEN-1:0] w;
        w = '0;
        if (p < KW_LEN[k]) w = KW_TEXT[k] >> (8 * (KW_LEN[k] - 1 - p));
        return w[6:0];
    endfunction

endpackage

FILE: hdl/script_lexer.sv
// ----------------------------------------------------------------------------
// script_lexer
// Streaming tokenizer for a small C-like expression language.
// ----------------------------------------------------------------------------
// One code point is taken per transfer and classified in a single pass into a
// three-slot result register. While m_ready is high the register drains one
// result per cycle and an item yielding at most one result is taken every
// cycle; an item yielding more (up to 3) holds the input side while the
// register drains. Keywords are matched incrementally per character against
// a fixed table, so no word store is read back. After an error or end of file
// the block drops all further input until reset. No clearing pass after reset.
module script_lexer #(
    parameter int MAX_WORD_LEN = slex_pkg::MAX_WORD_LEN_DEF,
    parameter int POS_WIDTH    = slex_pkg::POS_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [20:0]          s_code_point,
    input  logic                 s_end_of_input,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [20:0]          m_text_char,
    output logic [6:0]           m_token_type,
    output logic [3:0]           m_error_code,
    output logic [POS_WIDTH-1:0] m_line,
    output logic [POS_WIDTH-1:0] m_column,
    output logic                 m_last
);

    localparam int WLW = $clog2(MAX_WORD_LEN + 2);
    localparam int NKW = slex_pkg::NUM_KW;

    typedef struct packed {
        slex_pkg::lex_mode_t mode;
        logic [WLW-1:0]      wlen;
        logic [NKW-1:0]      match;
        logic [31:0]         esc;
        logic [3:0]          hexn;
        logic [6:0]          ptype;
        logic [21:0]         held;
    } lex_state_t;

    typedef struct packed {
        lex_state_t                s;
        slex_pkg::res_t [2:0]      r;
        logic [1:0]                n;
    } step_t;

    function automatic step_t f_emit(input step_t t, input logic [1:0] k,
                                     input logic [20:0] x, input logic [6:0] y,
                                     input logic [3:0] e);
        if (t.n != 2'd3) begin
            t.r[t.n] = '{kind: k, text: x, ttype: y, err: e};
            t.n = t.n + 2'd1;
        end
        return t;
    endfunction

    function automatic step_t f_text(input step_t t, input logic [21:0] c);
        return f_emit(t, slex_pkg::KIND_TEXT, c[20:0], slex_pkg::TT_NONE, 4'd0);
    endfunction

    function automatic step_t f_done(input step_t t, input logic [6:0] y);
        return f_emit(t, slex_pkg::KIND_DONE, 21'd0, y, 4'd0);
    endfunction

    function automatic step_t f_fail(input step_t t, input logic [3:0] e);
        t = f_emit(t, slex_pkg::KIND_ERROR, 21'd0, slex_pkg::TT_NONE, e);
        t.s.mode = slex_pkg::MODE_END;
        return t;
    endfunction

    function automatic step_t f_pend(input step_t t, input logic [6:0] y);
        t.s.ptype = y;
        t.s.mode = slex_pkg::MODE_PEND;
        return t;
    endfunction

    function automatic step_t f_word_add(input step_t t, input logic [21:0] c);
        if (int'(t.s.wlen) < MAX_WORD_LEN) begin
            for (int k = 0; k < NKW; k++) begin
                t.s.match[k] = t.s.match[k] && (int'(t.s.wlen) < slex_pkg::KW_LEN[k])
                    && (slex_pkg::kw_char(k, int'(t.s.wlen)) == c[6:0]);
            end
            t.s.wlen = t.s.wlen + 1'b1;
        end else begin
            t.s.wlen = WLW'(MAX_WORD_LEN + 1);
        end
        return t;
    endfunction

    function automatic logic [6:0] f_word_type(input lex_state_t s);
        logic [6:0] y;
        y = slex_pkg::TT_IDENT;
        if (int'(s.wlen) <= MAX_WORD_LEN) begin
            for (int k = 0; k < NKW; k++) begin
                if (s.match[k] && int'(s.wlen) == slex_pkg::KW_LEN[k])
                    y = slex_pkg::KW_TYPE[k];
            end
        end
        return y;
    endfunction

    function automatic step_t f_start(input step_t t, input logic [21:0] c);
        logic [6:0] y;
        y = slex_pkg::single_type(c);
        t.s.mode = slex_pkg::MODE_IDLE;
        if (c == slex_pkg::CP_EOF) begin
            t = f_emit(t, slex_pkg::KIND_EOF, 21'd0, slex_pkg::TT_NONE, 4'd0);
            t.s.mode = slex_pkg::MODE_END;
        end else if (slex_pkg::is_space(c)) begin
            t.s.mode = slex_pkg::MODE_IDLE;
        end else if (slex_pkg::is_ch(c, "/")) begin
            t.s.mode = slex_pkg::MODE_SLASH;
        end else if (slex_pkg::is_ch(c, ".")) begin
            t = f_text(t, c);
            t.s.mode = slex_pkg::MODE_DOT;
        end else if (slex_pkg::is_digit(c)) begin
            t = f_text(t, c);
            t.s.mode = slex_pkg::MODE_INT;
        end else if (slex_pkg::is_alpha(c) || slex_pkg::is_ch(c, "_")) begin
            t = f_text(t, c);
            t.s.wlen = '0;
            t.s.match = '1;
            t = f_word_add(t, c);
            t.s.mode = slex_pkg::MODE_WORD;
        end else if (slex_pkg::is_ch(c, "\"")) begin
            t.s.mode = slex_pkg::MODE_STR;
        end else if (y != slex_pkg::TT_NONE) begin
            t = f_text(t, c);
            t = f_pend(t, y);
        end else if (slex_pkg::is_ch(c, "<")) begin
            t = f_text(t, c);
            t.s.mode = slex_pkg::MODE_LT;
        end else if (slex_pkg::is_ch(c, ">")) begin
            t = f_text(t, c);
            t.s.mode = slex_pkg::MODE_GT;
        end else if (slex_pkg::is_ch(c, "=")) begin
            t = f_text(t, c);
            t.s.mode = slex_pkg::MODE_EQ;
        end else if (slex_pkg::is_ch(c, "*")) begin
            t = f_text(t, c);
            t.s.mode = slex_pkg::MODE_STAR;
        end else if (slex_pkg::is_ch(c, "!")) begin
            t = f_text(t, c);
            t.s.mode = slex_pkg::MODE_BANG;
        end else begin
            t = f_fail(t, slex_pkg::ERR_ILLEGAL_CHAR);
        end
        return t;
    endfunction

    function automatic step_t f_two(input step_t t, input logic [21:0] c,
                                    input logic [7:0] second, input logic [6:0] both,
                                    input logic [6:0] one);
        if (slex_pkg::is_ch(c, second)) begin
            t = f_text(t, c);
            t = f_pend(t, both);
        end else begin
            t = f_done(t, one);
            t = f_start(t, c);
        end
        return t;
    endfunction

    function automatic step_t f_hex(input step_t t, input logic [21:0] c,
                                    input logic [3:0] need, input logic wide);
        logic [4:0]  d;
        logic [31:0] v;
        d = slex_pkg::hex_val(c);
        v = {t.s.esc[27:0], d[3:0]};
        if (d[4]) begin
            t = f_fail(t, slex_pkg::ERR_HEX_DIGIT);
        end else begin
            t.s.esc = v;
            t.s.hexn = t.s.hexn + 4'd1;
            if (t.s.hexn >= need) begin
                if (need > 4'd2 && v >= slex_pkg::SURR_LO && v <= slex_pkg::SURR_HI) begin
                    t.s.mode = slex_pkg::MODE_BADSURR;
                end else if (wide && v >= slex_pkg::CP_LIMIT) begin
                    t.s.mode = slex_pkg::MODE_BADRANGE;
                end else begin
                    t = f_text(t, {1'b0, v[20:0]});
                    t.s.mode = slex_pkg::MODE_STR;
                end
            end
        end
        return t;
    endfunction

    function automatic step_t f_escape(input step_t t, input logic [21:0] c);
        logic [20:0] v;
        logic        ok;
        logic        hex;
        v = 21'd0;
        ok = 1'b1;
        hex = 1'b0;
        if (c[21:8] != 14'd0) begin
            ok = 1'b0;
        end else begin
            case (c[7:0])
                "\\": v = 21'h5C;
                "\"": v = 21'h22;
                "'": v = 21'h27;
                "a": v = 21'd7;
                "b": v = 21'd8;
                "e": v = slex_pkg::CP_ESC;
                "f": v = 21'd12;
                "n": v = 21'd10;
                "r": v = 21'd13;
                "t": v = 21'd9;
                "v": v = 21'd11;
                "0": v = 21'd0;
                "x": begin
                    hex = 1'b1;
                    t.s.mode = slex_pkg::MODE_HEX2;
                end
                "u": begin
                    hex = 1'b1;
                    t.s.mode = slex_pkg::MODE_HEX4;
                end
                "U": begin
                    hex = 1'b1;
                    t.s.mode = slex_pkg::MODE_HEX8;
                end
                default: ok = 1'b0;
            endcase
        end
        if (!ok) begin
            t = f_fail(t, slex_pkg::ERR_BAD_ESCAPE);
        end else if (hex) begin
            t.s.esc = '0;
            t.s.hexn = '0;
        end else begin
            t = f_text(t, {1'b0, v});
            t.s.mode = slex_pkg::MODE_STR;
        end
        return t;
    endfunction

    function automatic step_t f_core(input step_t t, input logic [21:0] c);
        logic eof;
        eof = (c == slex_pkg::CP_EOF);
        case (t.s.mode)
            slex_pkg::MODE_IDLE: t = f_start(t, c);
            slex_pkg::MODE_SLASH: begin
                if (slex_pkg::is_ch(c, "/")) t.s.mode = slex_pkg::MODE_LCOM;
                else if (slex_pkg::is_ch(c, "*")) t.s.mode = slex_pkg::MODE_BCOM;
                else begin
                    t = f_text(t, 22'h2F);
                    t = f_done(t, slex_pkg::TT_SLASH);
                    t = f_start(t, c);
                end
            end
            slex_pkg::MODE_LCOM: begin
                if (eof) t = f_start(t, c);
                else if (slex_pkg::is_ch(c, 8'h0A)) t.s.mode = slex_pkg::MODE_IDLE;
            end
            slex_pkg::MODE_BCOM, slex_pkg::MODE_SBCOM: begin
                if (eof) t = f_fail(t, slex_pkg::ERR_UNCLOSED_COMMENT);
                else if (slex_pkg::is_ch(c, "*"))
                    t.s.mode = (t.s.mode == slex_pkg::MODE_BCOM) ?
                        slex_pkg::MODE_BSTAR : slex_pkg::MODE_SBSTAR;
            end
            slex_pkg::MODE_BSTAR, slex_pkg::MODE_SBSTAR: begin
                if (eof) t = f_fail(t, slex_pkg::ERR_UNCLOSED_COMMENT);
                else if (slex_pkg::is_ch(c, "/"))
                    t.s.mode = (t.s.mode == slex_pkg::MODE_BSTAR) ?
                        slex_pkg::MODE_IDLE : slex_pkg::MODE_SCLOSE;
                else if (!slex_pkg::is_ch(c, "*"))
                    t.s.mode = (t.s.mode == slex_pkg::MODE_BSTAR) ?
                        slex_pkg::MODE_BCOM : slex_pkg::MODE_SBCOM;
            end
            slex_pkg::MODE_DOT: begin
                if (slex_pkg::is_digit(c)) begin
                    t = f_text(t, c);
                    t.s.mode = slex_pkg::MODE_FRAC;
                end else begin
                    t = f_done(t, slex_pkg::TT_DOT);
                    t = f_start(t, c);
                end
            end
            slex_pkg::MODE_INT, slex_pkg::MODE_FRAC: begin
                if (slex_pkg::is_digit(c)) begin
                    t = f_text(t, c);
                end else if (t.s.mode == slex_pkg::MODE_INT && slex_pkg::is_ch(c, ".")) begin
                    t = f_text(t, c);
                    t.s.mode = slex_pkg::MODE_FRAC;
                end else if (slex_pkg::is_ch(c, "e")) begin
                    t = f_text(t, c);
                    t.s.mode = slex_pkg::MODE_EXP;
                end else if (slex_pkg::is_ch(c, "f")) begin
                    t = f_text(t, c);
                    t = f_pend(t, slex_pkg::TT_FLOAT);
                end else begin
                    t = f_done(t, (t.s.mode == slex_pkg::MODE_INT) ?
                        slex_pkg::TT_INTEGER : slex_pkg::TT_FLOAT);
                    t = f_start(t, c);
                end
            end
            slex_pkg::MODE_EXP: begin
                if (slex_pkg::is_ch(c, "+") || slex_pkg::is_ch(c, "-")) begin
                    t = f_text(t, c);
                    t.s.mode = slex_pkg::MODE_ESIGN;
                end else if (slex_pkg::is_digit(c)) begin
                    t = f_text(t, c);
                    t.s.mode = slex_pkg::MODE_EDIG;
                end else begin
                    t = f_fail(t, slex_pkg::ERR_EXP_DIGITS);
                end
            end
            slex_pkg::MODE_ESIGN: begin
                if (slex_pkg::is_digit(c)) begin
                    t = f_text(t, c);
                    t.s.mode = slex_pkg::MODE_EDIG;
                end else begin
                    t = f_fail(t, slex_pkg::ERR_EXP_DIGITS);
                end
            end
            slex_pkg::MODE_EDIG: begin
                if (slex_pkg::is_digit(c)) begin
                    t = f_text(t, c);
                end else if (slex_pkg::is_ch(c, "f")) begin
                    t = f_text(t, c);
                    t = f_pend(t, slex_pkg::TT_FLOAT);
                end else begin
                    t = f_done(t, slex_pkg::TT_FLOAT);
                    t = f_start(t, c);
                end
            end
            slex_pkg::MODE_WORD: begin
                if (slex_pkg::is_word(c)) begin
                    t = f_text(t, c);
                    t = f_word_add(t, c);
                end else begin
                    t = f_done(t, f_word_type(t.s));
                    t = f_start(t, c);
                end
            end
            slex_pkg::MODE_STR: begin
                if (eof) t = f_fail(t, slex_pkg::ERR_UNCLOSED_STRING);
                else if (slex_pkg::is_ch(c, "\"")) t.s.mode = slex_pkg::MODE_SCLOSE;
                else if (slex_pkg::is_ch(c, 8'h5C)) t.s.mode = slex_pkg::MODE_ESC;
                else t = f_text(t, c);
            end
            slex_pkg::MODE_SCLOSE: begin
                if (slex_pkg::is_space(c)) t.s.mode = slex_pkg::MODE_SCLOSE;
                else if (slex_pkg::is_ch(c, "/")) t.s.mode = slex_pkg::MODE_SSLASH;
                else if (slex_pkg::is_ch(c, "\"")) t.s.mode = slex_pkg::MODE_STR;
                else begin
                    t = f_done(t, slex_pkg::TT_STRING);
                    t = f_start(t, c);
                end
            end
            slex_pkg::MODE_SSLASH: begin
                if (slex_pkg::is_ch(c, "/")) t.s.mode = slex_pkg::MODE_SLCOM;
                else if (slex_pkg::is_ch(c, "*")) t.s.mode = slex_pkg::MODE_SBCOM;
                else begin
                    t = f_done(t, slex_pkg::TT_STRING);
                    t = f_text(t, 22'h2F);
                    t = f_done(t, slex_pkg::TT_SLASH);
                    if (eof) t.s.mode = slex_pkg::MODE_EOFPEND;
                    else begin
                        t.s.held = c;
                        t.s.mode = slex_pkg::MODE_HELD;
                    end
                end
            end
            slex_pkg::MODE_SLCOM: begin
                if (eof) begin
                    t = f_done(t, slex_pkg::TT_STRING);
                    t = f_start(t, c);
                end else if (slex_pkg::is_ch(c, 8'h0A)) begin
                    t.s.mode = slex_pkg::MODE_SCLOSE;
                end
            end
            slex_pkg::MODE_ESC: t = f_escape(t, c);
            slex_pkg::MODE_HEX2: t = f_hex(t, c, 4'd2, 1'b0);
            slex_pkg::MODE_HEX4: t = f_hex(t, c, 4'd4, 1'b0);
            slex_pkg::MODE_HEX8: t = f_hex(t, c, 4'd8, 1'b1);
            slex_pkg::MODE_BADSURR: t = f_fail(t, slex_pkg::ERR_SURROGATE);
            slex_pkg::MODE_BADRANGE: t = f_fail(t, slex_pkg::ERR_RANGE);
            slex_pkg::MODE_LT: t = f_two(t, c, "=", slex_pkg::TT_LE, slex_pkg::TT_LT);
            slex_pkg::MODE_GT: t = f_two(t, c, "=", slex_pkg::TT_GE, slex_pkg::TT_GT);
            slex_pkg::MODE_EQ: t = f_two(t, c, "=", slex_pkg::TT_EQ, slex_pkg::TT_ASSIGN);
            slex_pkg::MODE_STAR: t = f_two(t, c, "*", slex_pkg::TT_POWER, slex_pkg::TT_STAR);
            slex_pkg::MODE_BANG: begin
                if (slex_pkg::is_ch(c, "=")) begin
                    t = f_text(t, c);
                    t = f_pend(t, slex_pkg::TT_NE);
                end else begin
                    t = f_fail(t, slex_pkg::ERR_LONE_BANG);
                end
            end
            slex_pkg::MODE_PEND: begin
                t = f_done(t, t.s.ptype);
                t = f_start(t, c);
            end
            slex_pkg::MODE_EOFPEND: begin
                t = f_emit(t, slex_pkg::KIND_EOF, 21'd0, slex_pkg::TT_NONE, 4'd0);
                t.s.mode = slex_pkg::MODE_END;
            end
            default: t.s.mode = slex_pkg::MODE_END;
        endcase
        return t;
    endfunction

    lex_state_t                 state_reg;
    logic [POS_WIDTH-1:0]       line_reg;
    logic [POS_WIDTH-1:0]       col_reg;
    logic                       nl_reg;
    slex_pkg::res_t [2:0]       res_reg;
    logic [1:0]                 cnt_reg;
    logic [POS_WIDTH-1:0]       oline_reg;
    logic [POS_WIDTH-1:0]       ocol_reg;

    step_t                step_next;
    logic [21:0]          cp;
    logic                 accept;
    logic                 pop;
    logic                 live;
    logic                 move;
    logic [POS_WIDTH-1:0] line_next;
    logic [POS_WIDTH-1:0] col_next;

    assign cp     = s_end_of_input ? slex_pkg::CP_EOF : {1'b0, s_code_point};
    assign s_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign accept = s_valid && s_ready;
    assign pop    = m_valid && m_ready;
    assign live   = state_reg.mode != slex_pkg::MODE_END;
    assign move   = live && state_reg.mode != slex_pkg::MODE_EOFPEND;

    always_comb begin
        line_next = line_reg;
        col_next  = col_reg;
        if (move) begin
            if (nl_reg) begin
                if (line_reg != '1) line_next = line_reg + 1'b1;
                col_next = POS_WIDTH'(1);
            end else if (col_reg != '1) begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb begin
        step_next   = '0;
        step_next.s = state_reg;
        if (live) begin
            if (state_reg.mode == slex_pkg::MODE_HELD) begin
                step_next = f_start(step_next, state_reg.held);
                if (step_next.s.mode != slex_pkg::MODE_END)
                    step_next = f_core(step_next, cp);
            end else begin
                step_next = f_core(step_next, cp);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: slex_pkg::MODE_IDLE, default: '0};
            line_reg  <= POS_WIDTH'(1);
            col_reg   <= '0;
            nl_reg    <= 1'b0;
            cnt_reg   <= 2'd0;
        end else begin
            if (accept && live) begin
                state_reg <= step_next.s;
                line_reg  <= line_next;
                col_reg   <= col_next;
                if (move) nl_reg <= !s_end_of_input && (s_code_point == 21'h0A);
            end
            if (accept && step_next.n != 2'd0) cnt_reg <= step_next.n;
            else if (pop) cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && step_next.n != 2'd0) begin
            res_reg   <= step_next.r;
            oline_reg <= line_next;
            ocol_reg  <= col_next;
        end else if (pop) begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    assign m_valid      = cnt_reg != 2'd0;
    assign m_kind       = res_reg[0].kind;
    assign m_text_char  = res_reg[0].text;
    assign m_token_type = res_reg[0].ttype;
    assign m_error_code = res_reg[0].err;
    assign m_line       = oline_reg;
    assign m_column     = ocol_reg;
    assign m_last       = cnt_reg == 2'd1;

`include "assert_macros.svh"

    `ASSERT_RST(a_end_sticks, aclk, aresetn,
        state_reg.mode == slex_pkg::MODE_END |=> state_reg.mode == slex_pkg::MODE_END)
    `ASSERT_RST(a_error_last, aclk, aresetn,
        m_valid && m_kind == slex_pkg::KIND_ERROR |-> m_last)
    `ASSERT_RST(a_eof_last, aclk, aresetn,
        m_valid && m_kind == slex_pkg::KIND_EOF |-> m_last)
    `ASSERT_CLK(a_ready_when_empty, aclk, !m_valid |-> s_ready)

endmodule
